### rtl/core/keyed_balance_table_assert.svh
// assertion macros shared by the keyed balance table checkers
`ifndef KEYED_BALANCE_TABLE_ASSERT_SVH
`define KEYED_BALANCE_TABLE_ASSERT_SVH

// same-cycle implication, off during reset
`define KBT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define KBT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/kbt_pkg.sv
// shared types and codes for the keyed balance table
`default_nettype none

package kbt_pkg;

  localparam int KBT_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 64;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_POS  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ENTRY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

  // write request into the entry store
  typedef struct packed {
    logic              key_we;
    logic              val_we;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } kbt_wr_t;

endpackage

`default_nettype wire

### rtl/core/kbt_store.sv
// key and value memories, one registered read port each and a shared write port
`default_nettype none

module kbt_store
  import kbt_pkg::*;
#(
  parameter int ENTRIES = KBT_ENTRIES,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire logic             key_re,
  input  wire logic [IW-1:0]    key_raddr,
  output      logic [KEY_W-1:0] key_rdata,
  input  wire logic             val_re,
  input  wire logic [IW-1:0]    val_raddr,
  output      logic [VAL_W-1:0] val_rdata,
  input  wire logic [IW-1:0]    wr_addr,
  input  wire kbt_wr_t          wr
);

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [VAL_W-1:0] val_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr_addr] <= wr.key;
    end
    if (key_re) begin
      key_rdata <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[wr_addr] <= wr.value;
    end
    if (val_re) begin
      val_rdata <= val_mem[val_raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/keyed_balance_table.sv
// top level of the keyed balance table
`default_nettype none

// Associative table of up to ENTRIES asset balances (signed 64-bit) keyed by a
// 32-bit asset id. Commands: add, subtract, get; each item yields exactly one
// result item with the balance after the operation, whether the key existed
// before, and a status code. Items are handled one at a time: after acceptance
// the key memory is scanned serially, one key per cycle through its single
// read port, each key compared in the cycle after its read; then the value is
// read (S_READ) and written back in a read-modify-write step (S_CALC), which
// registers the result and waits while a previous result is held by out_stall.
// The next item is accepted in the cycle after the result is registered. The
// result sits in an output register, so the next item is taken while the
// previous result still waits. Valid bits live in flip-flops cleared by
// reset; no clearing pass is needed.
module keyed_balance_table
  import kbt_pkg::*;
#(
  parameter int ENTRIES = KBT_ENTRIES
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic [CMD_W-1:0]           cmd,
  input  wire logic [KEY_W-1:0]           lookup_key,
  input  wire logic signed [VAL_W-1:0]    amount,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic signed [VAL_W-1:0]    balance,
  output      logic                       found,
  output      logic [STATUS_W-1:0]        status
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_CALC} state_t;

  state_t                  state;
  logic [CMD_W-1:0]        cmd_q;
  logic [KEY_W-1:0]        key_q;
  logic signed [VAL_W-1:0] amt_q;
  logic [IW-1:0]           scan_idx;
  logic                    issue_en;
  logic [IW-1:0]           cmp_idx;
  logic                    cmp_en;
  logic                    hit;
  logic [IW-1:0]           slot;
  logic                    free_found;
  logic [IW-1:0]           free_idx;
  logic [ENTRIES-1:0]      valid_bits;

  logic [KEY_W-1:0]        key_rdata;
  logic [VAL_W-1:0]        val_rdata;
  logic                    key_re;
  logic                    val_re;

  logic signed [VAL_W-1:0] bal_cur;
  logic signed [VAL_W-1:0] sum;
  logic signed [VAL_W-1:0] diff;
  logic                    amt_pos;
  logic signed [VAL_W-1:0] res_bal;
  logic [STATUS_W-1:0]     res_status;
  kbt_wr_t                 wr_req;
  kbt_wr_t                 wr_go;
  logic [IW-1:0]           wr_addr;
  logic                    fire;

  assign in_stall = rst || (state != S_IDLE);
  assign key_re   = (state == S_SCAN) && issue_en;
  assign val_re   = (state == S_READ);
  assign fire     = (state == S_CALC) && (!out_valid || !out_stall);

  kbt_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_store (
    .clk       (clk),
    .key_re    (key_re),
    .key_raddr (scan_idx),
    .key_rdata (key_rdata),
    .val_re    (val_re),
    .val_raddr (slot),
    .val_rdata (val_rdata),
    .wr_addr   (wr_addr),
    .wr        (wr_go)
  );

  // decide the result and the write-back from the fetched entry
  always_comb begin
    bal_cur    = hit ? $signed(val_rdata) : '0;
    amt_pos    = !amt_q[VAL_W-1] && (amt_q != '0);
    sum        = bal_cur + amt_q;
    diff       = bal_cur - amt_q;
    res_bal    = bal_cur;
    res_status = ST_OK;
    wr_req     = '0;
    wr_addr    = slot;
    if (cmd_q == CMD_ADD || cmd_q == CMD_SUB) begin
      if (!amt_pos) begin
        res_status = ST_NOT_POS;
      end else if (cmd_q == CMD_ADD) begin
        if (hit) begin
          if (!bal_cur[VAL_W-1] && sum[VAL_W-1]) begin
            res_status = ST_OVERFLOW;
          end else begin
            res_bal       = sum;
            wr_req.val_we = 1'b1;
            wr_req.value  = sum;
          end
        end else if (!free_found) begin
          res_status = ST_FULL;
        end else begin
          // new entry in the lowest free slot
          wr_addr       = free_idx;
          wr_req.key_we = 1'b1;
          wr_req.val_we = 1'b1;
          wr_req.key    = key_q;
          wr_req.value  = amt_q;
          res_bal       = amt_q;
        end
      end else begin
        if (!hit) begin
          res_status = ST_NO_ENTRY;
        end else if (bal_cur[VAL_W-1] && !diff[VAL_W-1]) begin
          res_status = ST_OVERFLOW;
        end else begin
          res_bal       = diff;
          wr_req.val_we = 1'b1;
          wr_req.value  = diff;
        end
      end
    end
    wr_go        = wr_req;
    wr_go.key_we = wr_req.key_we && fire;
    wr_go.val_we = wr_req.val_we && fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      valid_bits <= '0;
      issue_en   <= 1'b0;
      cmp_en     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= cmd;
            key_q      <= lookup_key;
            amt_q      <= amount;
            scan_idx   <= '0;
            issue_en   <= 1'b1;
            cmp_en     <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // compare stage runs in the cycle after its key read
          cmp_en  <= issue_en;
          cmp_idx <= scan_idx;
          if (issue_en) begin
            if (scan_idx == LAST) begin
              issue_en <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          if (cmp_en) begin
            if (valid_bits[cmp_idx] && key_rdata == key_q) begin
              hit  <= 1'b1;
              slot <= cmp_idx;
            end
            if (!valid_bits[cmp_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
            if (cmp_idx == LAST) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (fire) begin
            out_valid <= 1'b1;
            balance   <= res_bal;
            found     <= hit;
            status    <= res_status;
            if (wr_req.key_we) begin
              valid_bits[free_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/kbt_checker.sv
// port-level checks for the keyed balance table, bound to the top level
`default_nettype none

`include "keyed_balance_table_assert.svh"

module kbt_checker
  import kbt_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [VAL_W-1:0] balance,
  input wire logic                    found,
  input wire logic [STATUS_W-1:0]     status
);

  `KBT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(balance) && $stable(found) && $stable(status), "stalled result changed")
  `KBT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "item accepted while previous item still in flight")
  `KBT_ASSERT_NOW(a_no_entry_zero, clk, rst, out_valid && status == ST_NO_ENTRY, balance == 0 && !found, "missing entry result not zero")
  `KBT_ASSERT_NOW(a_full_zero, clk, rst, out_valid && status == ST_FULL, balance == 0 && !found, "full table result not zero")

endmodule

bind keyed_balance_table kbt_checker u_kbt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .balance   (balance),
  .found     (found),
  .status    (status)
);

`default_nettype wire

### tb/sv/kbt_ledger_pkg.sv
// scoreboard class: shadow copy of the balance table and the queue of pending results
package kbt_ledger_pkg;
  import kbt_pkg::*;

  localparam logic signed [VAL_W-1:0] BAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] BAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [VAL_W-1:0]    balance;
    logic                found;
    logic [STATUS_W-1:0] status;
  } kbt_reply_t;

  class kbt_ledger;
    logic [KEY_W-1:0]        slot_key  [KBT_ENTRIES];
    logic signed [VAL_W-1:0] slot_bal  [KBT_ENTRIES];
    bit                      slot_used [KBT_ENTRIES];
    kbt_reply_t              pending_q [$];
    int unsigned             errors;
    int unsigned             accepted;
    int unsigned             replies;
    int unsigned             status_seen [8];

    function new();
      errors   = 0;
      accepted = 0;
      replies  = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int find_key(logic [KEY_W-1:0] key);
      for (int i = 0; i < KBT_ENTRIES; i++)
        if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    function int first_free();
      for (int i = 0; i < KBT_ENTRIES; i++)
        if (!slot_used[i]) return i;
      return -1;
    endfunction

    // update the shadow table for one accepted item and queue its result
    function void note_item(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                            logic signed [VAL_W-1:0] amt);
      int                      hit;
      int                      spare;
      logic signed [VAL_W-1:0] bal;
      kbt_reply_t              r;
      hit = find_key(key);
      bal = '0;
      if (hit >= 0) bal = slot_bal[hit];
      r.status = ST_OK;
      if (cmd == CMD_ADD || cmd == CMD_SUB) begin
        if (amt <= 0) begin
          r.status = ST_NOT_POS;
        end else if (cmd == CMD_ADD) begin
          if (hit >= 0) begin
            if (bal > BAL_MAX - amt) begin
              r.status = ST_OVERFLOW;
            end else begin
              bal = bal + amt;
              slot_bal[hit] = bal;
            end
          end else begin
            spare = first_free();
            if (spare < 0) begin
              r.status = ST_FULL;
            end else begin
              slot_used[spare] = 1'b1;
              slot_key[spare]  = key;
              slot_bal[spare]  = amt;
              bal = amt;
            end
          end
        end else begin
          if (hit < 0) begin
            r.status = ST_NO_ENTRY;
          end else if (bal < BAL_MIN + amt) begin
            r.status = ST_OVERFLOW;
          end else begin
            bal = bal - amt;
            slot_bal[hit] = bal;
          end
        end
      end
      // anything else, including the unused selector code, reads the balance
      r.balance = bal;
      r.found   = (hit >= 0);
      status_seen[r.status]++;
      accepted++;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic signed [VAL_W-1:0] bal, logic hit,
                               logic [STATUS_W-1:0] st);
      kbt_reply_t want;
      replies++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: balance %0d found %0b status %0d", bal, hit, st);
        return;
      end
      want = pending_q.pop_front();
      if (want.balance !== bal || want.found !== hit || want.status !== st) begin
        errors++;
        if (errors <= 10)
          $display("result %0d differs: expected balance %0d found %0b status %0d, got %0d %0b %0d",
                   replies, $signed(want.balance), want.found, want.status, bal, hit, st);
      end
    endfunction

    function void close_out();
      if (pending_q.size() > 0) begin
        errors++;
        $display("%0d expected results never arrived", pending_q.size());
      end
    endfunction
  endclass

endpackage

### tb/sv/keyed_balance_table_test.sv
// top-level testbench for the keyed balance table
module keyed_balance_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kbt_pkg::*;
  import kbt_ledger_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int IDLE_PCT    = 6;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1080;
  localparam int POOL_SIZE   = 24;
  localparam int TAIL_CYCLES = 40;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CMD_W-1:0]        cmd = CMD_GET;
  logic [KEY_W-1:0]        lookup_key = '0;
  logic signed [VAL_W-1:0] amount = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] balance;
  logic                    found;
  logic [STATUS_W-1:0]     status;

  kbt_ledger        ledger = new();
  bit               calm = 1'b0;
  bit               hold_req = 1'b0;
  int unsigned      held_cycles = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  keyed_balance_table u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .lookup_key (lookup_key),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .balance    (balance),
    .found      (found),
    .status     (status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [VAL_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                           input logic signed [VAL_W-1:0] a);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    lookup_key <= k;
    amount     <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_item(c, k, a);
  endtask

  // order matters: entries are never removed, so key zero is built up step by step
  task automatic run_directed();
    send_item(CMD_GET, '0, rand64());
    send_item(CMD_SUB, '0, 64'sd5);
    send_item(CMD_ADD, '0, '0);
    send_item(CMD_ADD, '0, '1);
    send_item(CMD_ADD, '0, BAL_MIN);
    send_item(CMD_SUB, '0, '0);
    send_item(CMD_ADD, '0, BAL_MAX);
    send_item(CMD_ADD, '0, 64'sd1);
    send_item(CMD_SUB, '0, BAL_MAX);
    send_item(CMD_SUB, '0, BAL_MAX);
    send_item(CMD_SUB, '0, 64'sd1);
    send_item(CMD_SUB, '0, 64'sd1);
    send_item(CMD_SPARE, '0, rand64());
    send_item(CMD_ADD, '1, 64'sd1);
    send_item(CMD_ADD, '1, BAL_MAX);
    send_item(CMD_SUB, '1, 64'sd2);
    send_item(CMD_ADD, '0, BAL_MAX);
    send_item(CMD_GET, '1, BAL_MIN);
    send_item(CMD_SUB, '0, '1);
    send_item(CMD_SUB, '0, BAL_MIN);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return VAL_W'($urandom_range(1, 100000));
    if (r < 65) return rand64() & BAL_MAX;
    if (r < 75) return BAL_MAX - VAL_W'($urandom_range(0, 1000));
    if (r < 82) return '0;
    if (r < 90) return rand64() | BAL_MIN;
    if (r < 93) return BAL_MIN;
    return rand64();
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_ADD;
    if (r < 70) return CMD_SUB;
    if (r < 95) return CMD_GET;
    return CMD_SPARE;
  endfunction

  // most items hit a small key set so entries get reused and the table fills
  task automatic run_random();
    logic [KEY_W-1:0] k;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) hold_req = 1'b1;
      calm = (i >= 500 && i < 700);
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, POOL_SIZE-1)];
      else k = $urandom();
      send_item(pick_cmd(), k, pick_amount());
    end
    calm = 1'b0;
  endtask

  // result side: check every accepted result, stall at random or for one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        ledger.check_result(balance, found, status);
      if (hold_left > 0) begin
        hold_left--;
        held_cycles++;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        held_cycles++;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    waited = 0;
    while (ledger.pending_q.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    ledger.close_out();
    $display("covered %0d items and %0d results, with a %0d-cycle output hold-off",
             ledger.accepted, ledger.replies, held_cycles);
    $display("outcomes: ok %0d, non-positive %0d, no entry %0d, full %0d, overflow %0d",
             ledger.status_seen[ST_OK], ledger.status_seen[ST_NOT_POS],
             ledger.status_seen[ST_NO_ENTRY], ledger.status_seen[ST_FULL],
             ledger.status_seen[ST_OVERFLOW]);
    if (ledger.errors == 0)
      $display("keyed_balance_table: match");
    else
      $display("keyed_balance_table: mismatch");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timed out with %0d results outstanding", ledger.pending_q.size());
    $display("keyed_balance_table: mismatch");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/kbt_pkg.sv
rtl/core/kbt_store.sv
rtl/core/keyed_balance_table.sv
rtl/core/kbt_checker.sv
tb/sv/kbt_ledger_pkg.sv
tb/sv/keyed_balance_table_test.sv
